FILE: hw/rtl/ttg_pkg.sv
// ttg_pkg: shared types, constants and helper functions of the tangent generator
// used by every module under hw/rtl; depends on nothing
`default_nettype none

package ttg_pkg;

  // fixed point constants
  localparam logic signed [31:0] ONE_Q30     = 32'sh4000_0000;
  localparam logic signed [31:0] NEG_ONE_Q30 = -32'sh4000_0000;
  localparam int FIT_BITS   = 31;
  localparam int CORNERS    = 3;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 31;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = 2;

  typedef logic signed [30:0] q30_t;
  typedef logic signed [31:0] nrm_t;

  // input word: one triangle corner
  typedef struct packed {
    logic [15:0]        vertex_index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] nrm_x;
    logic signed [31:0] nrm_y;
    logic signed [31:0] nrm_z;
    logic signed [31:0] tex_u;
    logic signed [31:0] tex_v;
  } in_word_t;

  // output word: one tangent
  typedef struct packed {
    logic [15:0]        out_index;
    logic signed [31:0] tan_x;
    logic signed [31:0] tan_y;
    logic signed [31:0] tan_z;
    logic               degenerate;
    logic               last_of_triangle;
  } out_word_t;

  // one projection job from front to back
  typedef struct packed {
    logic [15:0] index;
    q30_t        tx;
    q30_t        ty;
    q30_t        tz;
    nrm_t        nx;
    nrm_t        ny;
    nrm_t        nz;
    logic        det_zero;
    logic        last;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [2:0] {
    F_IDLE, F_SQUEEZE, F_MUL, F_DIFF, F_NEG, F_TSQUEEZE, F_PUSH
  } front_state_t;

  typedef enum logic [3:0] {
    B_IDLE, B_DOT_MUL, B_DOT_SUM, B_PROJ_MUL, B_PROJ, B_SQZ_CALC, B_SQZ,
    B_SQUARE, B_SUM, B_SQRT, B_DIV_INIT, B_DIV, B_DONE
  } back_state_t;

  // signed bit length of a value
  function automatic logic [6:0] sig_len(input logic signed [63:0] x);
    logic [6:0] len;
    len = 7'd1;
    for (int i = 0; i < 63; i++) begin
      if (x[i] != x[63]) len = 7'(i + 2);
    end
    return len;
  endfunction

  // smallest floor shift that brings x into [-2^30, 2^30)
  function automatic logic [5:0] fit_shift(input logic signed [63:0] x);
    logic [6:0] len;
    len = sig_len(x);
    return (len > 7'(FIT_BITS)) ? 6'(len - 7'(FIT_BITS)) : 6'd0;
  endfunction

  function automatic logic [5:0] max6(input logic [5:0] a, input logic [5:0] b);
    return (a > b) ? a : b;
  endfunction

  // clamp a normal component to +-1.0
  function automatic nrm_t sat_normal(input logic signed [31:0] x);
    nrm_t r;
    r = x;
    if (x > ONE_Q30) r = ONE_Q30;
    if (x < NEG_ONE_Q30) r = NEG_ONE_Q30;
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/triangle_tangent_generator.sv
// triangle_tangent_generator: corner intake, job queue and tangent normalizer
// the first two corners of a triangle are only held; after the third is accepted, intake
// stalls while the front forms the tangent and queues three jobs, also while the queue is full
// each tangent is normalized in the back end with the 32-step square root
// and the 31-step divider, one tangent at a time
// rst (synchronous) clears the corner count, state machines, queue and output valid
// depends on ttg_pkg, ttg_front, ttg_queue, ttg_back
`default_nettype none

module triangle_tangent_generator import ttg_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  logic      push, pop;
  job_t      push_job, pop_job;
  q_status_t q_status;

  ttg_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .push     (push),
    .push_job (push_job),
    .q_status (q_status)
  );

  ttg_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .status   (q_status)
  );

  ttg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop       (pop),
    .pop_job   (pop_job),
    .q_status  (q_status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/ttg_front.sv
// ttg_front: takes corners, holds two, forms the scaled triangle tangent
// and pushes one job per corner; depends on ttg_pkg
`default_nettype none

module ttg_front import ttg_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      push,
  output job_t      push_job,
  input  q_status_t q_status
);

  front_state_t state, state_next;
  logic [1:0] corner_count;
  logic [1:0] push_k;

  logic [15:0]        hidx [3];
  nrm_t               hn   [3][3];
  logic signed [31:0] hp   [2][3];
  logic signed [31:0] huv  [2][2];

  logic signed [32:0] dp  [6];
  logic signed [32:0] du  [4];
  q30_t               sdp [6];
  q30_t               sdu [4];
  logic signed [61:0] pdet0, pdet1;
  logic signed [61:0] pt0 [3];
  logic signed [61:0] pt1 [3];
  logic signed [62:0] det;
  logic signed [62:0] traw [3];
  logic signed [63:0] tneg [3];
  q30_t               tq   [3];
  logic               det_zero;

  logic signed [31:0] ipos [3];
  logic signed [31:0] inrm [3];
  logic signed [31:0] iuv  [2];
  logic               accept;
  logic [5:0]         sh_p, sh_u, sh_t;

  assign ipos[0] = in_data.pos_x;
  assign ipos[1] = in_data.pos_y;
  assign ipos[2] = in_data.pos_z;
  assign inrm[0] = in_data.nrm_x;
  assign inrm[1] = in_data.nrm_y;
  assign inrm[2] = in_data.nrm_z;
  assign iuv[0]  = in_data.tex_u;
  assign iuv[1]  = in_data.tex_v;

  // group shifts for the deltas and the raw tangent
  always_comb begin
    sh_p = 6'd0;
    sh_u = 6'd0;
    sh_t = 6'd0;
    for (int i = 0; i < 6; i++) sh_p = max6(sh_p, fit_shift(64'(dp[i])));
    for (int i = 0; i < 4; i++) sh_u = max6(sh_u, fit_shift(64'(du[i])));
    for (int i = 0; i < 3; i++) sh_t = max6(sh_t, fit_shift(tneg[i]));
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      F_IDLE:     if (accept && corner_count == 2'd2) state_next = F_SQUEEZE;
      F_SQUEEZE:  state_next = F_MUL;
      F_MUL:      state_next = F_DIFF;
      F_DIFF:     state_next = F_NEG;
      F_NEG:      state_next = F_TSQUEEZE;
      F_TSQUEEZE: state_next = F_PUSH;
      F_PUSH:     if (push && push_k == 2'd2) state_next = F_IDLE;
      default:    state_next = F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall = 1'b1;
    push     = 1'b0;
    case (state)
      F_IDLE:  in_stall = 1'b0;
      F_PUSH:  push = !q_status.full;
      default: ;
    endcase
  end

  assign accept = in_valid && !in_stall;

  // job word for the current corner
  always_comb begin
    push_job.index    = hidx[push_k];
    push_job.tx       = tq[0];
    push_job.ty       = tq[1];
    push_job.tz       = tq[2];
    push_job.nx       = hn[push_k][0];
    push_job.ny       = hn[push_k][1];
    push_job.nz       = hn[push_k][2];
    push_job.det_zero = det_zero;
    push_job.last     = (push_k == 2'd2);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= F_IDLE;
      corner_count <= 2'd0;
      push_k       <= 2'd0;
    end else begin
      state <= state_next;
      if (accept) corner_count <= (corner_count == 2'd2) ? 2'd0 : corner_count + 2'd1;
      if (push) push_k <= (push_k == 2'd2) ? 2'd0 : push_k + 2'd1;
    end
  end

  // corner capture and tangent datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      hidx[corner_count] <= in_data.vertex_index;
      for (int i = 0; i < 3; i++) hn[corner_count][i] <= sat_normal(inrm[i]);
      if (corner_count != 2'd2) begin
        for (int i = 0; i < 3; i++) hp[corner_count[0]][i] <= ipos[i];
        for (int i = 0; i < 2; i++) huv[corner_count[0]][i] <= iuv[i];
      end else begin
        for (int i = 0; i < 3; i++) begin
          dp[i]     <= 33'(hp[1][i]) - 33'(hp[0][i]);
          dp[3 + i] <= 33'(ipos[i]) - 33'(hp[0][i]);
        end
        du[0] <= 33'(huv[1][0]) - 33'(huv[0][0]);
        du[1] <= 33'(huv[1][1]) - 33'(huv[0][1]);
        du[2] <= 33'(iuv[0]) - 33'(huv[0][0]);
        du[3] <= 33'(iuv[1]) - 33'(huv[0][1]);
      end
    end
    case (state)
      F_SQUEEZE: begin
        for (int i = 0; i < 6; i++) sdp[i] <= 31'(dp[i] >>> sh_p);
        for (int i = 0; i < 4; i++) sdu[i] <= 31'(du[i] >>> sh_u);
      end
      F_MUL: begin
        pdet0 <= sdu[0] * sdu[3];
        pdet1 <= sdu[1] * sdu[2];
        for (int i = 0; i < 3; i++) begin
          pt0[i] <= sdp[i] * sdu[3];
          pt1[i] <= sdp[3 + i] * sdu[1];
        end
      end
      F_DIFF: begin
        det <= 63'(pdet0) - 63'(pdet1);
        for (int i = 0; i < 3; i++) traw[i] <= 63'(pt0[i]) - 63'(pt1[i]);
      end
      F_NEG: begin
        det_zero <= (det == '0);
        for (int i = 0; i < 3; i++) tneg[i] <= det[62] ? -64'(traw[i]) : 64'(traw[i]);
      end
      F_TSQUEEZE: begin
        for (int i = 0; i < 3; i++) tq[i] <= 31'(tneg[i] >>> sh_t);
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ttg_queue.sv
// ttg_queue: short job queue between front and back
// depends on ttg_pkg
`default_nettype none

module ttg_queue import ttg_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  job_t      push_job,
  input  logic      pop,
  output job_t      pop_job,
  output q_status_t status
);

  job_t entry [Q_DEPTH];
  logic [Q_PTR_W-1:0] wptr, rptr;
  logic [Q_PTR_W:0]   count;

  assign pop_job      = entry[rptr];
  assign status.full  = (count == (Q_PTR_W + 1)'(Q_DEPTH));
  assign status.empty = (count == '0);

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) entry[wptr] <= push_job;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ttg_back.sv
// ttg_back: projects the tangent off one normal, normalizes it with a
// digit-serial square root and divider, and holds the output word; depends on ttg_pkg
`default_nettype none

module ttg_back import ttg_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  output logic      pop,
  input  job_t      pop_job,
  input  q_status_t q_status,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  back_state_t state, state_next;
  logic [4:0] step;

  job_t               job;
  logic               deg;
  logic signed [62:0] dprod [3];
  logic signed [33:0] d;
  logic signed [63:0] dn [3];
  logic signed [63:0] p  [3];
  logic               pzero;
  logic [5:0]         shp;
  q30_t               q  [3];
  logic signed [61:0] sq [3];
  logic [63:0]        sx, sres, sbit;
  logic [61:0]        rem [3];
  logic [61:0]        den [3];
  logic [30:0]        quo [3];

  q30_t        jt [3];
  nrm_t        jn [3];
  logic        load, out_free;
  logic [63:0] trial;
  logic [5:0]  sh_calc;
  logic signed [63:0] dot;
  logic [30:0] len;
  logic [30:0] mag [3];

  assign jt[0] = job.tx;
  assign jt[1] = job.ty;
  assign jt[2] = job.tz;
  assign jn[0] = job.nx;
  assign jn[1] = job.ny;
  assign jn[2] = job.nz;

  assign trial = sres + sbit;
  assign dot   = 64'(dprod[0]) + 64'(dprod[1]) + 64'(dprod[2]);
  assign len   = sres[30:0];

  // projected tangent vanished
  assign pzero = (p[0] == '0) && (p[1] == '0) && (p[2] == '0);

  always_comb begin
    sh_calc = 6'd0;
    for (int i = 0; i < 3; i++) begin
      sh_calc = max6(sh_calc, fit_shift(p[i]));
      mag[i]  = q[i][30] ? 31'(-q[i]) : 31'(q[i]);
    end
  end

  assign out_free = !out_valid || !out_stall;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:     if (!q_status.empty) state_next = pop_job.det_zero ? B_DONE : B_DOT_MUL;
      B_DOT_MUL:  state_next = B_DOT_SUM;
      B_DOT_SUM:  state_next = B_PROJ_MUL;
      B_PROJ_MUL: state_next = B_PROJ;
      B_PROJ:     state_next = B_SQZ_CALC;
      B_SQZ_CALC: state_next = pzero ? B_DONE : B_SQZ;
      B_SQZ:      state_next = B_SQUARE;
      B_SQUARE:   state_next = B_SUM;
      B_SUM:      state_next = B_SQRT;
      B_SQRT:     if (step == 5'(SQRT_STEPS - 1)) state_next = B_DIV_INIT;
      B_DIV_INIT: state_next = B_DIV;
      B_DIV:      if (step == 5'(DIV_STEPS - 1)) state_next = B_DONE;
      B_DONE:     if (out_free) state_next = B_IDLE;
      default:    state_next = B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop  = 1'b0;
    load = 1'b0;
    case (state)
      B_IDLE:  pop = !q_status.empty;
      B_DONE:  load = out_free;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      step      <= 5'd0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == B_SQRT || state == B_DIV) begin
        step <= (state_next == state) ? step + 5'd1 : 5'd0;
      end
      if (load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // projection and normalize datapath
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        job <= pop_job;
        deg <= pop_job.det_zero;
      end
      B_DOT_MUL: begin
        for (int i = 0; i < 3; i++) dprod[i] <= jt[i] * jn[i];
      end
      B_DOT_SUM: d <= 34'(dot >>> 30);
      B_PROJ_MUL: begin
        for (int i = 0; i < 3; i++) dn[i] <= d * jn[i];
      end
      B_PROJ: begin
        for (int i = 0; i < 3; i++) p[i] <= (64'(jt[i]) <<< 30) - dn[i];
      end
      B_SQZ_CALC: begin
        shp <= sh_calc;
        deg <= pzero;
      end
      B_SQZ: begin
        for (int i = 0; i < 3; i++) q[i] <= 31'(p[i] >>> shp);
      end
      B_SQUARE: begin
        for (int i = 0; i < 3; i++) sq[i] <= q[i] * q[i];
      end
      B_SUM: begin
        sx   <= 64'(sq[0]) + 64'(sq[1]) + 64'(sq[2]);
        sres <= 64'd0;
        sbit <= 64'd1 << 62;
      end
      // one root digit per cycle
      B_SQRT: begin
        if (sx >= trial) begin
          sx   <= sx - trial;
          sres <= (sres >> 1) + sbit;
        end else begin
          sres <= sres >> 1;
        end
        sbit <= sbit >> 2;
      end
      B_DIV_INIT: begin
        for (int i = 0; i < 3; i++) begin
          rem[i] <= (62'(mag[i]) << 30) + 62'(len >> 1);
          den[i] <= 62'(len) << 30;
          quo[i] <= 31'd0;
        end
      end
      // one quotient bit per cycle in each lane
      B_DIV: begin
        for (int i = 0; i < 3; i++) begin
          if (rem[i] >= den[i]) begin
            rem[i] <= rem[i] - den[i];
            quo[i] <= {quo[i][29:0], 1'b1};
          end else begin
            quo[i] <= {quo[i][29:0], 1'b0};
          end
          den[i] <= den[i] >> 1;
        end
      end
      default: ;
    endcase
    // output word
    if (load) begin
      out_data.out_index        <= job.index;
      out_data.degenerate       <= deg;
      out_data.last_of_triangle <= job.last;
      out_data.tan_x <= deg ? 32'sd0 : (q[0][30] ? -32'(quo[0]) : 32'(quo[0]));
      out_data.tan_y <= deg ? 32'sd0 : (q[1][30] ? -32'(quo[1]) : 32'(quo[1]));
      out_data.tan_z <= deg ? 32'sd0 : (q[2][30] ? -32'(quo[2]) : 32'(quo[2]));
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ttg_checker.sv
// ttg_checker: port-level assertions on the tangent generator, bound to the top
// depends on ttg_pkg
`default_nettype none

module ttg_checker import ttg_pkg::*; (
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire in_word_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_word_t out_data
);

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  // degenerate word carries a zero tangent
  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.degenerate |->
      out_data.tan_x == 32'sd0 && out_data.tan_y == 32'sd0 && out_data.tan_z == 32'sd0)
    else $error("degenerate word with nonzero tangent");

  // normalized components stay within one
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      out_data.tan_x >= NEG_ONE_Q30 && out_data.tan_x <= ONE_Q30 &&
      out_data.tan_y >= NEG_ONE_Q30 && out_data.tan_y <= ONE_Q30 &&
      out_data.tan_z >= NEG_ONE_Q30 && out_data.tan_z <= ONE_Q30)
    else $error("tangent component out of range");

  // a good tangent is never zero
  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.degenerate |->
      out_data.tan_x != 32'sd0 || out_data.tan_y != 32'sd0 || out_data.tan_z != 32'sd0)
    else $error("zero tangent without degenerate flag");

endmodule

bind triangle_tangent_generator ttg_checker u_ttg_checker (.*);

`default_nettype wire

FILE: tb/testbench.sv
// testbench: randomized and directed check of triangle_tangent_generator
// predicts tangents per triangle in the scoreboard class; depends on ttg_pkg and the rtl
`timescale 1ns / 1ps

module testbench;
  import ttg_pkg::*;

  localparam longint Q30 = 64'sd1 << 30;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_data;

  int unsigned cycle_cnt;
  bit          quiet_phase;

  triangle_tangent_generator i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // tangent predictor and queue of pending tangents
  class tangent_scoreboard;
    out_word_t   pending[$];
    int unsigned n_errors;
    int          corner_cnt;
    in_word_t    held[2];

    function longint fshift(longint x, int s);
      return x >>> s;
    endfunction

    // smallest common shift into [-2^30, 2^30), applied in place
    function void squeeze(ref longint v[6], input int n);
      int s;
      bit ok;
      for (s = 0; s < 62; s++) begin
        ok = 1;
        for (int i = 0; i < n; i++)
          if (fshift(v[i], s) < -Q30 || fshift(v[i], s) >= Q30) ok = 0;
        if (ok) break;
      end
      for (int i = 0; i < n; i++) v[i] = fshift(v[i], s);
    endfunction

    function longint sat_nrm(logic signed [31:0] x);
      longint v;
      v = x;
      if (v > Q30) v = Q30;
      if (v < -Q30) v = -Q30;
      return v;
    endfunction

    function longint unsigned root(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x -= r + b;
          r = (r >> 1) + b;
        end else r >>= 1;
        b >>= 2;
      end
      return r;
    endfunction

    // project t off the normal and normalize; returns degenerate
    function bit project(longint t[6], longint n[3], output longint r[3]);
      longint p[6];
      longint dot, d;
      longint unsigned sum, len, mag, q;
      dot = 0;
      for (int i = 0; i < 3; i++) dot += t[i] * n[i];
      d = dot >>> 30;
      for (int i = 0; i < 6; i++) p[i] = 0;
      for (int i = 0; i < 3; i++) p[i] = t[i] * Q30 - d * n[i];
      r = '{0, 0, 0};
      if (p[0] == 0 && p[1] == 0 && p[2] == 0) return 1;
      squeeze(p, 3);
      sum = 0;
      for (int i = 0; i < 3; i++) sum += longint'(p[i] * p[i]);
      len = root(sum);
      for (int i = 0; i < 3; i++) begin
        mag = p[i] < 0 ? -p[i] : p[i];
        q = ((mag << 30) + (len >> 1)) / len;
        r[i] = p[i] < 0 ? -longint'(q) : longint'(q);
      end
      return 0;
    endfunction

    function void note_corner(in_word_t w);
      in_word_t c[3];
      longint dp[6], du[6], t[6], n[3], r[3], det;
      out_word_t o;
      bit deg;
      if (corner_cnt < 2) begin
        held[corner_cnt] = w;
        corner_cnt++;
        return;
      end
      corner_cnt = 0;
      c[0] = held[0];
      c[1] = held[1];
      c[2] = w;
      dp[0] = longint'(c[1].pos_x) - c[0].pos_x;
      dp[1] = longint'(c[1].pos_y) - c[0].pos_y;
      dp[2] = longint'(c[1].pos_z) - c[0].pos_z;
      dp[3] = longint'(c[2].pos_x) - c[0].pos_x;
      dp[4] = longint'(c[2].pos_y) - c[0].pos_y;
      dp[5] = longint'(c[2].pos_z) - c[0].pos_z;
      du[0] = longint'(c[1].tex_u) - c[0].tex_u;
      du[1] = longint'(c[1].tex_v) - c[0].tex_v;
      du[2] = longint'(c[2].tex_u) - c[0].tex_u;
      du[3] = longint'(c[2].tex_v) - c[0].tex_v;
      du[4] = 0;
      du[5] = 0;
      squeeze(dp, 6);
      squeeze(du, 4);
      det = du[0] * du[3] - du[1] * du[2];
      for (int i = 0; i < 6; i++) t[i] = 0;
      for (int i = 0; i < 3; i++) begin
        t[i] = dp[i] * du[3] - dp[3 + i] * du[1];
        if (det < 0) t[i] = -t[i];
      end
      squeeze(t, 3);
      for (int k = 0; k < 3; k++) begin
        n[0] = sat_nrm(c[k].nrm_x);
        n[1] = sat_nrm(c[k].nrm_y);
        n[2] = sat_nrm(c[k].nrm_z);
        r = '{0, 0, 0};
        deg = 1;
        if (det != 0) deg = project(t, n, r);
        o.out_index = c[k].vertex_index;
        o.tan_x = r[0][31:0];
        o.tan_y = r[1][31:0];
        o.tan_z = r[2][31:0];
        o.degenerate = deg;
        o.last_of_triangle = (k == 2);
        pending.push_back(o);
      end
    endfunction

    function void check_tangent(out_word_t got);
      out_word_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word, actual %p", $time, got);
        n_errors++;
        return;
      end
      e = pending.pop_front();
      if (got.out_index !== e.out_index) begin
        $display("%0t: out_index expected %0d actual %0d", $time, e.out_index, got.out_index);
        n_errors++;
      end
      if (got.tan_x !== e.tan_x) begin
        $display("%0t: tan_x expected %0d actual %0d", $time, e.tan_x, got.tan_x);
        n_errors++;
      end
      if (got.tan_y !== e.tan_y) begin
        $display("%0t: tan_y expected %0d actual %0d", $time, e.tan_y, got.tan_y);
        n_errors++;
      end
      if (got.tan_z !== e.tan_z) begin
        $display("%0t: tan_z expected %0d actual %0d", $time, e.tan_z, got.tan_z);
        n_errors++;
      end
      if (got.degenerate !== e.degenerate) begin
        $display("%0t: degenerate expected %0b actual %0b", $time, e.degenerate,
                 got.degenerate);
        n_errors++;
      end
      if (got.last_of_triangle !== e.last_of_triangle) begin
        $display("%0t: last_of_triangle expected %0b actual %0b", $time,
                 e.last_of_triangle, got.last_of_triangle);
        n_errors++;
      end
    endfunction
  endclass

  tangent_scoreboard tangents;

  // clock and cycle limit
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 400000) begin
      $display("** triangle_tangent_generator: FAILED **");
      $finish;
    end
  end

  // receiver side: random stall bursts, checks each accepted word
  initial begin
    int burst;
    out_stall = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall && !rst) tangents.check_tangent(out_data);
      if (burst > 0) burst--;
      else if (!quiet_phase && $urandom_range(0, 5) == 0) burst = $urandom_range(1, 11);
      out_stall <= (burst > 0);
    end
  end

  function automatic logic signed [31:0] rnd_nrm();
    case ($urandom_range(0, 5))
      0: return 32'sh4000_0000;
      1: return -32'sh4000_0000;
      2: return $urandom;
      default: return $signed(32'($urandom_range(0, 32'h8000_0000))) - 32'sh4000_0000;
    endcase
  endfunction

  function automatic logic signed [31:0] rnd_wide();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return 32'sh7fff_ffff;
      2: return 32'sh8000_0000;
      default: return $signed(32'($urandom_range(0, 32'h0010_0000))) - 32'sh0008_0000;
    endcase
  endfunction

  function automatic in_word_t rnd_corner();
    in_word_t w;
    w.vertex_index = $urandom;
    w.pos_x = rnd_wide();
    w.pos_y = rnd_wide();
    w.pos_z = rnd_wide();
    w.nrm_x = rnd_nrm();
    w.nrm_y = rnd_nrm();
    w.nrm_z = rnd_nrm();
    w.tex_u = rnd_wide();
    w.tex_v = rnd_wide();
    return w;
  endfunction

  function automatic in_word_t mk_corner(logic [15:0] idx, int px, int py, int pz,
                                         int nx, int ny, int nz, int u, int v);
    in_word_t w;
    w = '{idx, px, py, pz, nx, ny, nz, u, v};
    return w;
  endfunction

  // send one corner, with an optional random gap ahead of it
  task automatic send_corner(in_word_t w);
    if (!quiet_phase && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    tangents.note_corner(w);
  endtask

  localparam int ONE = 32'h4000_0000;

  initial begin
    in_word_t w;
    tangents = new();
    cycle_cnt = 0;
    quiet_phase = 0;
    rst = 1;
    in_valid = 0;
    in_data = '0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // simple triangle, normal along z
    send_corner(mk_corner(16'd0, 0, 0, 0, 0, 0, ONE, 0, 0));
    send_corner(mk_corner(16'd1, 32'h10000, 0, 0, 0, 0, ONE, 32'h10000, 0));
    send_corner(mk_corner(16'hffff, 0, 32'h10000, 0, 0, 0, ONE, 0, 32'h10000));
    // zero uv determinant
    send_corner(mk_corner(16'd5, 0, 0, 0, ONE, 0, 0, 7, 7));
    send_corner(mk_corner(16'd6, 32'h10000, 0, 0, ONE, 0, 0, 7, 7));
    send_corner(mk_corner(16'd7, 0, 32'h10000, 0, ONE, 0, 0, 7, 7));
    // tangent along y, positive det, out of range normals
    send_corner(mk_corner(16'd8, 0, 0, 0, ONE, 0, 0, 0, 0));
    send_corner(mk_corner(16'd8, 32'h10000, 0, 0, 32'h7fffffff, 32'h80000000, 0,
                          0, -32'h10000));
    send_corner(mk_corner(16'd8, 0, 32'h10000, 0, 0, ONE, -ONE, 32'h10000, 0));
    // extreme deltas
    send_corner(mk_corner(16'd9, 32'h80000000, 32'h7fffffff, 32'h80000000, -ONE, 0, 0,
                          32'h80000000, 32'h80000000));
    send_corner(mk_corner(16'd10, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, -ONE, 0,
                          32'h7fffffff, 32'h80000000));
    send_corner(mk_corner(16'd11, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 0, 0, -ONE,
                          32'h80000000, 32'h7fffffff));

    // wait for the block to drain once
    in_valid <= 0;
    while (tangents.pending.size() != 0) @(posedge clk);

    for (int i = 0; i < 120; i++) begin
      if (i >= 96) quiet_phase = 1;
      w = rnd_corner();
      if ($urandom_range(0, 9) == 0) w.tex_v = tangents.held[0].tex_v;
      send_corner(w);
    end
    in_valid <= 0;

    while (tangents.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (tangents.n_errors == 0)
      $display("** triangle_tangent_generator: PASSED **");
    else
      $display("** triangle_tangent_generator: FAILED **");
    $finish;
  end
endmodule
